### design/aip_pkg.sv
// aip_pkg: shared types and constants for the ASCII integer parser.
// No dependencies.
package aip_pkg;

    typedef enum logic [2:0]
    {
        PH_START,
        PH_FIRST,
        PH_ZERO,
        PH_XSEEN,
        PH_HEXZERO,
        PH_DIGITS,
        PH_IGNORE
    } phase_t;

    // classified character handed from front to back
    typedef struct packed
    {
        logic       last;
        logic       is_digit;
        logic [3:0] digit;
        logic       is_x;
        logic       is_minus;
    } aip_item_t;

    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;
    localparam logic [7:0] CHAR_UPPER_X = 8'h58;
    localparam logic [7:0] CHAR_LOWER_X = 8'h78;

    localparam logic [4:0] BASE_AUTO = 5'd0;
    localparam logic [4:0] BASE_OCT  = 5'd8;
    localparam logic [4:0] BASE_DEC  = 5'd10;
    localparam logic [4:0] BASE_HEX  = 5'd16;

    // register index is paddr[2]
    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_ACCEPT_SIGN = 1'b1;

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] n);
        logic [16:0] s;
        s = {1'b0, a} + {15'd0, n};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

### design/aip_front.sv
// aip_front: accepts characters, classifies them and queues them (2 entries).
// Depends on aip_pkg.
module aip_front
    import aip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tlast,
    output logic       item_valid,
    output aip_item_t  item,
    input  logic       item_pop
);

    aip_item_t  queue_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    aip_item_t  cls;
    logic       push;
    logic       pop;

    always_comb
    begin
        cls.last     = s_tlast;
        cls.is_minus = (s_tdata == CHAR_MINUS);
        cls.is_x     = (s_tdata == CHAR_UPPER_X) || (s_tdata == CHAR_LOWER_X);
        cls.is_digit = 1'b1;
        cls.digit    = 4'd0;
        if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE)
        begin
            cls.digit = 4'(s_tdata - CHAR_ZERO);
        end
        else if (s_tdata >= CHAR_UPPER_A && s_tdata <= CHAR_UPPER_F)
        begin
            cls.digit = 4'(s_tdata - CHAR_UPPER_A + 8'd10);
        end
        else if (s_tdata >= CHAR_LOWER_A && s_tdata <= CHAR_LOWER_F)
        begin
            cls.digit = 4'(s_tdata - CHAR_LOWER_A + 8'd10);
        end
        else
        begin
            cls.is_digit = 1'b0;
        end
    end

    assign s_tready   = (count_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != 2'd0);
    assign pop        = item_pop && item_valid;
    assign item       = queue_reg[rd_ptr_reg];

    assign wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### design/aip_back.sv
// aip_back: parse state machine, multiply-add accumulator and output register.
// Depends on aip_pkg.
module aip_back
    import aip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  number_base,
    input  logic        accept_sign,
    input  logic        item_valid,
    input  aip_item_t   item,
    output logic        item_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // [63:0] parsed_value, [79:64] chars_consumed
    output logic        m_tuser   // [0] ended_by_buffer
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [15:0] cnt_reg;
    logic [15:0] cnt_next;
    logic [4:0]  base_reg;
    logic [4:0]  base_next;
    logic        neg_reg;
    logic        neg_next;

    logic        out_valid_reg;
    logic [63:0] out_raw_reg;
    logic [15:0] out_cnt_reg;
    logic        out_neg_reg;
    logic        out_end_reg;

    logic        step;
    logic        emit;
    logic        by_end;
    logic        is_zero;
    logic        sign_path;
    logic        first_path;
    logic        first_oct;
    logic        first_hex;
    logic        take_path;
    logic [4:0]  take_base;
    logic        take_ok;
    logic [63:0] acc_src;
    logic [15:0] cnt_src;
    logic [63:0] prod;
    logic [1:0]  inc;

    assign step     = item_valid && (!out_valid_reg || m_tready);
    assign item_pop = step;

    assign is_zero    = item.is_digit && (item.digit == 4'd0);
    assign sign_path  = (phase_reg == PH_START) && accept_sign && item.is_minus;
    assign first_path = ((phase_reg == PH_START) && !sign_path) || (phase_reg == PH_FIRST);
    assign first_oct  = first_path && (number_base == BASE_AUTO) && is_zero;
    assign first_hex  = first_path && (number_base == BASE_HEX) && is_zero;
    assign take_path  = (first_path && !first_oct && !first_hex)
                     || ((phase_reg == PH_ZERO) && !item.is_x)
                     || ((phase_reg == PH_HEXZERO) && !item.is_x)
                     || (phase_reg == PH_DIGITS);
    assign take_base  = first_path ? ((number_base == BASE_AUTO) ? BASE_DEC : number_base)
                                   : base_reg;
    assign take_ok    = item.is_digit && ({1'b0, item.digit} < take_base);

    assign acc_src = (phase_reg == PH_START) ? 64'd0 : acc_reg;
    assign cnt_src = (phase_reg == PH_START) ? 16'd0 : cnt_reg;
    assign prod    = acc_src * {59'd0, take_base};

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_START, PH_FIRST:
            begin
                if (item.last)
                begin
                    phase_next = PH_START;
                end
                else if (sign_path)
                begin
                    phase_next = PH_FIRST;
                end
                else if (first_oct)
                begin
                    phase_next = PH_ZERO;
                end
                else if (first_hex)
                begin
                    phase_next = PH_HEXZERO;
                end
                else
                begin
                    phase_next = take_ok ? PH_DIGITS : PH_IGNORE;
                end
            end
            PH_ZERO:
            begin
                if (item.last)
                begin
                    phase_next = PH_START;
                end
                else if (item.is_x)
                begin
                    phase_next = PH_XSEEN;
                end
                else
                begin
                    phase_next = take_ok ? PH_DIGITS : PH_IGNORE;
                end
            end
            PH_XSEEN:
            begin
                if (item.last)
                begin
                    phase_next = PH_START;
                end
                else
                begin
                    phase_next = item.is_digit ? PH_DIGITS : PH_IGNORE;
                end
            end
            PH_HEXZERO:
            begin
                if (item.last)
                begin
                    phase_next = PH_START;
                end
                else if (item.is_x)
                begin
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = take_ok ? PH_DIGITS : PH_IGNORE;
                end
            end
            PH_DIGITS:
            begin
                if (item.last)
                begin
                    phase_next = PH_START;
                end
                else
                begin
                    phase_next = take_ok ? PH_DIGITS : PH_IGNORE;
                end
            end
            PH_IGNORE:
            begin
                phase_next = item.last ? PH_START : PH_IGNORE;
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        acc_next  = acc_src;
        base_next = base_reg;
        neg_next  = (phase_reg == PH_START) ? sign_path : neg_reg;
        inc       = 2'd0;
        emit      = 1'b0;
        by_end    = 1'b0;
        if (first_path)
        begin
            base_next = (number_base == BASE_AUTO) ? (is_zero ? BASE_OCT : BASE_DEC)
                                                   : number_base;
        end
        if (sign_path || first_oct || first_hex)
        begin
            inc    = 2'd1;
            by_end = 1'b1;
            emit   = item.last;
        end
        if (take_path)
        begin
            if (take_ok)
            begin
                acc_next = prod + {60'd0, item.digit};
                inc      = 2'd1;
                by_end   = 1'b1;
                emit     = item.last;
            end
            else
            begin
                emit = 1'b1;
            end
        end
        if ((phase_reg == PH_ZERO) && item.is_x)
        begin
            emit = item.last;
        end
        if (phase_reg == PH_XSEEN)
        begin
            if (item.is_digit)
            begin
                base_next = BASE_HEX;
                acc_next  = {60'd0, item.digit};
                inc       = 2'd2;
                by_end    = 1'b1;
                emit      = item.last;
            end
            else
            begin
                emit = 1'b1;
            end
        end
        if ((phase_reg == PH_HEXZERO) && item.is_x)
        begin
            inc    = 2'd1;
            by_end = 1'b1;
            emit   = item.last;
        end
        cnt_next = sat_add(cnt_src, inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= 64'd0;
            cnt_reg       <= 16'd0;
            base_reg      <= 5'd0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                base_reg  <= base_next;
                neg_reg   <= neg_next;
            end
            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            out_raw_reg <= acc_next;
            out_cnt_reg <= cnt_next;
            out_neg_reg <= neg_next;
            out_end_reg <= by_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_cnt_reg, out_neg_reg ? (64'd0 - out_raw_reg) : out_raw_reg};
    assign m_tuser  = out_end_reg;

endmodule

### design/ascii_integer_parser.sv
// An accepted character is queued in aip_front, then parsed into the output register.
// Throughput: one character per cycle unless the output stalls; the back end's single
// 64x5 multiply-add per cycle sets it; a 2-entry queue decouples input from the parser.
// Reset (rst_n low, asynchronous): queue emptied, parse back to start of number,
// no result pending, number_base and accept_sign cleared to 0.
// Depends on aip_pkg, aip_front, aip_back.
module ascii_integer_parser
    import aip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] char_code
    input  logic        s_tlast,  // buffer_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,  // [63:0] parsed_value, [79:64] chars_consumed
    output logic        m_tuser   // [0] ended_by_buffer
);

    logic [4:0] number_base_reg;
    logic       accept_sign_reg;
    logic       cfg_write;
    logic       item_valid;
    logic       item_pop;
    aip_item_t  item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= 5'd0;
            accept_sign_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_NUMBER_BASE: number_base_reg <= pwdata[4:0];
                REG_ACCEPT_SIGN: accept_sign_reg <= pwdata[0];
                default:         number_base_reg <= number_base_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_NUMBER_BASE: prdata = {27'd0, number_base_reg};
            REG_ACCEPT_SIGN: prdata = {31'd0, accept_sign_reg};
            default:         prdata = 32'd0;
        endcase
    end

    aip_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    aip_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .number_base (number_base_reg),
        .accept_sign (accept_sign_reg),
        .item_valid  (item_valid),
        .item        (item),
        .item_pop    (item_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

### design/aip_checker.sv
// aip_checker: port-level assertions for ascii_integer_parser, bound to the top level.
// Depends only on the top-level ports.
module aip_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tuser
);

    property p_hold_valid;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid;
    endproperty

    property p_hold_data;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser);
    endproperty

    // nothing consumed means nothing accumulated
    property p_empty_is_zero;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[79:64] == 16'd0) |-> (m_tdata[63:0] == 64'd0);
    endproperty

    // a buffer-ended parse always consumed at least one character
    property p_end_has_count;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[79:64] != 16'd0);
    endproperty

    a_hold_valid:    assert property (p_hold_valid)    else $error("m_tvalid dropped");
    a_hold_data:     assert property (p_hold_data)     else $error("result changed");
    a_empty_is_zero: assert property (p_empty_is_zero) else $error("value without chars");
    a_end_has_count: assert property (p_end_has_count) else $error("end with no chars");

endmodule

bind ascii_integer_parser aip_checker u_aip_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/tb_ascii_integer_parser.sv
// Self-checking testbench for ascii_integer_parser: streams character buffers through
// the block and checks each parse result against a predictor built into the scoreboard.
// Depends on aip_pkg and the ascii_integer_parser RTL.
module tb_ascii_integer_parser
    import aip_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [4:0]  NO_DIGIT    = 5'h1F;
    localparam int unsigned PHASE_ITEMS = 200;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_WAIT  = 10;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef struct packed
    {
        logic [63:0] value;
        logic [15:0] count;
        logic        by_end;
    } parse_result_t;

    class parse_scoreboard;
        logic [4:0]    number_base;
        logic          accept_sign;
        phase_t        cur_phase;
        logic [63:0]   acc;
        logic [15:0]   used;
        logic [4:0]    base_in_use;
        logic          negate;
        parse_result_t expected_q[$];
        int unsigned   mismatches;
        int unsigned   consumed_items;

        function new();
            number_base    = BASE_AUTO;
            accept_sign    = 1'b0;
            cur_phase      = PH_START;
            acc            = '0;
            used           = '0;
            base_in_use    = BASE_AUTO;
            negate         = 1'b0;
            mismatches     = 0;
            consumed_items = 0;
        endfunction

        function void write_config(logic idx, logic [31:0] data);
            if (idx == REG_NUMBER_BASE)
                number_base = data[4:0];
            else
                accept_sign = data[0];
        endfunction

        function logic [4:0] digit_of(logic [7:0] c);
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
                return 5'(c - CHAR_ZERO);
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
                return 5'(c - CHAR_UPPER_A + 8'd10);
            if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
                return 5'(c - CHAR_LOWER_A + 8'd10);
            return NO_DIGIT;
        endfunction

        function bit is_x_char(logic [7:0] c);
            return c == CHAR_UPPER_X || c == CHAR_LOWER_X;
        endfunction

        function void count_up(logic [1:0] n);
            logic [16:0] s;
            s = {1'b0, used} + {15'd0, n};
            used = s[16] ? 16'hFFFF : s[15:0];
        endfunction

        function void emit(logic by_end, logic last);
            parse_result_t r;
            r.value  = negate ? 64'd0 - acc : acc;
            r.count  = used;
            r.by_end = by_end;
            expected_q.push_back(r);
            cur_phase = last ? PH_START : PH_IGNORE;
        endfunction

        function void take_digit(logic [7:0] c, logic last);
            logic [4:0] d;
            d = digit_of(c);
            if (d != NO_DIGIT && d < base_in_use)
            begin
                acc = acc * {59'd0, base_in_use} + {59'd0, d};
                count_up(2'd1);
                cur_phase = PH_DIGITS;
                if (last)
                    emit(1'b1, last);
            end
            else
                emit(1'b0, last);
        endfunction

        function void first_char(logic [7:0] c, logic last);
            if (number_base == BASE_AUTO)
            begin
                if (c == CHAR_ZERO)
                begin
                    base_in_use = BASE_OCT;
                    count_up(2'd1);
                    cur_phase = PH_ZERO;
                    if (last)
                        emit(1'b1, last);
                end
                else
                begin
                    base_in_use = BASE_DEC;
                    take_digit(c, last);
                end
            end
            else
            begin
                base_in_use = number_base;
                if (number_base == BASE_HEX && c == CHAR_ZERO)
                begin
                    count_up(2'd1);
                    cur_phase = PH_HEXZERO;
                    if (last)
                        emit(1'b1, last);
                end
                else
                    take_digit(c, last);
            end
        endfunction

        function void note_request(logic [7:0] c, logic last);
            logic [4:0] d;
            consumed_items++;
            case (cur_phase)
                PH_START:
                begin
                    acc         = '0;
                    used        = '0;
                    negate      = 1'b0;
                    base_in_use = BASE_AUTO;
                    if (accept_sign && c == CHAR_MINUS)
                    begin
                        negate = 1'b1;
                        count_up(2'd1);
                        cur_phase = PH_FIRST;
                        if (last)
                            emit(1'b1, last);
                    end
                    else
                        first_char(c, last);
                end
                PH_FIRST:
                    first_char(c, last);
                PH_ZERO:
                begin
                    if (is_x_char(c))
                    begin
                        if (last)
                            emit(1'b0, last);
                        else
                            cur_phase = PH_XSEEN;
                    end
                    else
                        take_digit(c, last);
                end
                PH_XSEEN:
                begin
                    d = digit_of(c);
                    if (d != NO_DIGIT)
                    begin
                        base_in_use = BASE_HEX;
                        acc = {59'd0, d};
                        count_up(2'd2);
                        cur_phase = PH_DIGITS;
                        if (last)
                            emit(1'b1, last);
                    end
                    else
                        emit(1'b0, last);
                end
                PH_HEXZERO:
                begin
                    if (is_x_char(c))
                    begin
                        count_up(2'd1);
                        cur_phase = PH_DIGITS;
                        if (last)
                            emit(1'b1, last);
                    end
                    else
                        take_digit(c, last);
                end
                PH_DIGITS:
                    take_digit(c, last);
                default:
                begin
                    if (last)
                        cur_phase = PH_START;
                end
            endcase
        endfunction

        function void check_result(logic [63:0] value, logic [15:0] count, logic by_end);
            parse_result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %h count %0d end %0b",
                             value, count, by_end);
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.value !== value || want.count !== count || want.by_end !== by_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected value %h count %0d end %0b,",
                                  " got value %h count %0d end %0b"},
                                 want.value, want.count, want.by_end,
                                 value, count, by_end);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] char_code
    logic        s_tlast  = 1'b0; // buffer_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // [63:0] parsed_value, [79:64] chars_consumed
    logic        m_tuser;         // [0] ended_by_buffer

    parse_scoreboard sb;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    bit              hold_request   = 1'b0;
    int unsigned     hold_left      = 0;
    int unsigned     cycle_count    = 0;

    ascii_integer_parser uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[63:0], m_tdata[79:64], m_tuser);
    end

    function automatic logic [7:0] digit_char(int unsigned d);
        if (d < 10)
            return CHAR_ZERO + 8'(d);
        return ($urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] picks [8];
        picks = '{CHAR_MINUS, CHAR_ZERO, CHAR_UPPER_X, CHAR_LOWER_X,
                  CHAR_NINE, CHAR_LOWER_F, 8'h67, 8'h20};
        if ($urandom_range(1))
            return 8'($urandom_range(255));
        return picks[$urandom_range(7)];
    endfunction

    task automatic apb_write(input logic idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_config(idx, data);
    endtask

    task automatic send_item(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(c, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    task automatic send_random_buffer();
        logic [7:0]  chars_q[$];
        int unsigned radix;
        int unsigned ndig;
        int unsigned pick;
        if ($urandom_range(99) < 20)
        begin
            repeat ($urandom_range(1, 6))
                chars_q.push_back(noise_char());
        end
        else
        begin
            radix = sb.number_base;
            if ($urandom_range(3) == 0)
                chars_q.push_back(CHAR_MINUS);
            if (radix == BASE_AUTO)
            begin
                pick = $urandom_range(2);
                if (pick == 0)
                begin
                    radix = BASE_DEC;
                    chars_q.push_back(digit_char($urandom_range(1, 9)));
                end
                else
                begin
                    chars_q.push_back(CHAR_ZERO);
                    radix = BASE_OCT;
                    if (pick == 2)
                    begin
                        chars_q.push_back($urandom_range(1) ? CHAR_UPPER_X : CHAR_LOWER_X);
                        radix = BASE_HEX;
                    end
                end
            end
            else if (radix == BASE_HEX && $urandom_range(2) == 0)
            begin
                chars_q.push_back(CHAR_ZERO);
                chars_q.push_back($urandom_range(1) ? CHAR_UPPER_X : CHAR_LOWER_X);
            end
            if (radix > 16)
                radix = 16;
            ndig = ($urandom_range(9) == 0) ? $urandom_range(16, 30) : $urandom_range(0, 12);
            repeat (ndig)
                chars_q.push_back(digit_char($urandom_range(radix - 1)));
            if ($urandom_range(1) || chars_q.size() == 0)
            begin
                chars_q.push_back(noise_char());
                repeat ($urandom_range(3))
                    chars_q.push_back(noise_char());
            end
        end
        foreach (chars_q[i])
            send_item(chars_q[i], i == chars_q.size() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [4:0] base, input logic sign);
        apb_write(REG_NUMBER_BASE, {27'd0, base});
        apb_write(REG_ACCEPT_SIGN, {31'd0, sign});
    endtask

    task automatic run_phase(input logic [4:0] base, input logic sign,
                             input int unsigned idle, input int unsigned stall, input bit hold);
        int unsigned goal;
        drain();
        set_config(base, sign);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        if (hold)
            hold_request = 1'b1;
        goal = sb.consumed_items + PHASE_ITEMS;
        while (sb.consumed_items < goal)
            send_random_buffer();
        // sometimes leave a numeral open across the register update
        if ($urandom_range(1))
            send_item($urandom_range(1) ? CHAR_MINUS : CHAR_ZERO, 1'b0);
    endtask

    initial
    begin
        sb = new();
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(BASE_AUTO, 1'b1);
        send_text("0x");
        send_text("0xg");
        send_text("-0XfF");
        send_text("-");
        send_text("-z");
        send_text("q");
        send_text("0778");
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_item(CHAR_MINUS, 1'b0);

        run_phase(BASE_HEX,  1'b1, 0,  0,  1'b0);
        run_phase(BASE_AUTO, 1'b1, 74, 0,  1'b0);
        run_phase(BASE_DEC,  1'b0, 0,  74, 1'b0);
        run_phase(BASE_OCT,  1'b1, 36, 36, 1'b0);
        run_phase(5'd1,      1'b1, 0,  0,  1'b1);
        run_phase(5'd31,     1'b0, 74, 0,  1'b0);
        run_phase(5'd2,      1'b1, 0,  74, 1'b0);
        run_phase(BASE_AUTO, 1'b0, 36, 36, 1'b0);
        run_phase(BASE_HEX,  1'b0, 0,  0,  1'b0);

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

### files.f
design/aip_pkg.sv
design/aip_front.sv
design/aip_back.sv
design/ascii_integer_parser.sv
design/aip_checker.sv
verif/tb_ascii_integer_parser.sv
